/* rtl/slbm_pkg.sv */
package slbm_pkg;

	// Field widths fixed by the bus and the mapped memory space.
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int MAP_W   = 22;
	localparam int COUNT_W = 8;

	// Serial load register: five bits, loaded least significant bit first.
	localparam int SHIFT_W = 5;
	localparam int WCNT_W  = 3;

	localparam logic [SHIFT_W-1:0] SHIFT_INIT = 5'h10;
	// Number of earlier writes in a sequence at which the next write completes it.
	localparam logic [WCNT_W-1:0]  LAST_WRITE = 3'd4;

	// Configuration register indexes.
	localparam logic REG_PRG_BANK_COUNT = 1'b0;
	localparam logic REG_CHR_BANK_COUNT = 1'b1;

	localparam logic [COUNT_W-1:0] PRG_COUNT_RST = 8'd8;
	localparam logic [COUNT_W-1:0] CHR_COUNT_RST = 8'd0;

	// Access kinds.
	typedef enum logic [1:0] {
		CMD_CPU_WR = 2'd0,
		CMD_CPU_RD = 2'd1,
		CMD_PPU_RD = 2'd2,
		CMD_PPU_WR = 2'd3
	} cmd_t;

	// Target of a completed serial load, from address bits 14:13.
	typedef enum logic [1:0] {
		TGT_CONTROL = 2'd0,
		TGT_CHR0    = 2'd1,
		TGT_CHR1    = 2'd2,
		TGT_PRG     = 2'd3
	} tgt_t;

	// PRG banking modes.
	localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
	localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

	localparam logic [1:0] MIRROR_HORZ = 2'd3;

	// Banking state seen by the address translation.
	typedef struct packed {
		logic [1:0] prg_mode;
		logic       chr_mode;
		logic [1:0] mirror;
		logic [4:0] chr_lo;
		logic [4:0] chr_hi;
		logic [3:0] prg_sel;
	} bank_state_t;

endpackage

/* rtl/slbm_ctrl.sv */
// Serial load sequencer and banking registers. Presents the banking state
// as it stands after the transaction in flight has been applied.
module slbm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  slbm_pkg::cmd_t                cmd,
	input  logic [slbm_pkg::ADDR_W-1:0]   address,
	input  logic [slbm_pkg::DATA_W-1:0]   data,
	output slbm_pkg::bank_state_t         st_nxt
);

	logic [slbm_pkg::SHIFT_W-1:0] shift_q, shift_nxt, shift_new;
	logic [slbm_pkg::WCNT_W-1:0]  wcnt_q, wcnt_nxt;
	slbm_pkg::bank_state_t        st_q;
	slbm_pkg::tgt_t               tgt;

	assign tgt       = slbm_pkg::tgt_t'(address[14:13]);
	assign shift_new = {data[0], shift_q[slbm_pkg::SHIFT_W-1:1]};

	// Next-state logic for a CPU write into the mapper window.
	always_comb begin
		shift_nxt = shift_q;
		wcnt_nxt  = wcnt_q;
		st_nxt    = st_q;
		if (step && cmd == slbm_pkg::CMD_CPU_WR && address[15]) begin
			if (data[7]) begin
				// Reset write: restart the sequence and fix the last PRG bank.
				shift_nxt       = slbm_pkg::SHIFT_INIT;
				wcnt_nxt        = '0;
				st_nxt.prg_mode = slbm_pkg::PRG_MODE_FIX_LAST;
			end else if (wcnt_q == slbm_pkg::LAST_WRITE) begin
				shift_nxt = slbm_pkg::SHIFT_INIT;
				wcnt_nxt  = '0;
				unique case (tgt)
					slbm_pkg::TGT_CONTROL: begin
						st_nxt.mirror   = shift_new[1:0];
						st_nxt.prg_mode = shift_new[3:2];
						st_nxt.chr_mode = shift_new[4];
					end
					slbm_pkg::TGT_CHR0: st_nxt.chr_lo  = shift_new;
					slbm_pkg::TGT_CHR1: st_nxt.chr_hi  = shift_new;
					slbm_pkg::TGT_PRG:  st_nxt.prg_sel = shift_new[3:0];
					default:            st_nxt         = st_q;
				endcase
			end else begin
				shift_nxt = shift_new;
				wcnt_nxt  = wcnt_q + 3'd1;
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= slbm_pkg::SHIFT_INIT;
			wcnt_q      <= '0;
			st_q.prg_mode <= slbm_pkg::PRG_MODE_FIX_LAST;
			st_q.chr_mode <= 1'b0;
			st_q.mirror   <= slbm_pkg::MIRROR_HORZ;
			st_q.chr_lo   <= '0;
			st_q.chr_hi   <= '0;
			st_q.prg_sel  <= '0;
		end else begin
			shift_q <= shift_nxt;
			wcnt_q  <= wcnt_nxt;
			st_q    <= st_nxt;
		end
	end

endmodule

/* rtl/slbm_xlate.sv */
// Address translation for CPU reads and PPU accesses.
module slbm_xlate (
	input  slbm_pkg::cmd_t                 cmd,
	input  logic [slbm_pkg::ADDR_W-1:0]    address,
	input  slbm_pkg::bank_state_t          st,
	input  logic [slbm_pkg::COUNT_W-1:0]   prg_bank_count,
	input  logic [slbm_pkg::COUNT_W-1:0]   chr_bank_count,
	output logic                           hit,
	output logic [slbm_pkg::MAP_W-1:0]     mapped_address
);

	logic [slbm_pkg::COUNT_W-1:0] last_bank;
	logic                         chr_ram;
	logic                         ppu_win;

	assign last_bank = prg_bank_count - 8'd1;
	assign chr_ram   = (chr_bank_count == '0);
	assign ppu_win   = (address[15:13] == 3'b000);

	always_comb begin
		hit            = 1'b0;
		mapped_address = '0;
		unique case (cmd)
			slbm_pkg::CMD_CPU_WR: begin
				hit = 1'b0;
			end
			slbm_pkg::CMD_CPU_RD: begin
				if (address[15]) begin
					hit = 1'b1;
					unique case (st.prg_mode) inside
						slbm_pkg::PRG_MODE_32K_A, slbm_pkg::PRG_MODE_32K_B:
							mapped_address = {4'b0, st.prg_sel[3:1], address[14:0]};
						slbm_pkg::PRG_MODE_FIX_FIRST:
							mapped_address = address[14]
								? {4'b0, st.prg_sel, address[13:0]}
								: {8'b0, address[13:0]};
						default:
							mapped_address = address[14]
								? {last_bank, address[13:0]}
								: {4'b0, st.prg_sel, address[13:0]};
					endcase
				end
			end
			slbm_pkg::CMD_PPU_RD: begin
				if (ppu_win) begin
					hit = 1'b1;
					if (chr_ram) begin
						mapped_address = {9'b0, address[12:0]};
					end else if (!st.chr_mode) begin
						mapped_address = {5'b0, st.chr_lo[4:1], address[12:0]};
					end else if (address[12]) begin
						mapped_address = {5'b0, st.chr_hi, address[11:0]};
					end else begin
						mapped_address = {5'b0, st.chr_lo, address[11:0]};
					end
				end
			end
			default: begin
				// PPU write reaches only character RAM.
				if (ppu_win && chr_ram) begin
					hit            = 1'b1;
					mapped_address = {9'b0, address[12:0]};
				end
			end
		endcase
	end

endmodule

/* rtl/serial_loaded_bank_mapper_core.sv */
// Channel   | Port group               | Contents (low bits first)
// ----------+--------------------------+------------------------------------------
// input     | s_tvalid/s_tready        | tuser: cmd[1:0]; tdata: address[15:0], data[23:16]
// result    | m_tvalid/m_tready        | tuser: hit; tdata: mapped_address[21:0], mirror_mode[23:22]
// config    | cfg_we/cfg_index/cfg_data| 0 prg_bank_count, 1 chr_bank_count
//
// One transaction per cycle while the result side does not stall; a result passes the input register
// and then translation and state update into the result register before it is offered.
// arst_n clears the pipeline and loads the power-up banking state at once.
// A stall on the result side holds the result register; the input register still
// takes one more transaction if it is empty, and s_tready drops while it is full.
module serial_loaded_bank_mapper_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,  // address[15:0], data[23:16]
	input  logic [1:0]                       s_tuser,  // cmd[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,  // mapped_address[21:0], mirror_mode[23:22]
	output logic                             m_tuser,  // hit
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [slbm_pkg::COUNT_W-1:0]     cfg_data
);

	logic                          vld_s1;
	slbm_pkg::cmd_t                cmd_s1;
	logic [slbm_pkg::ADDR_W-1:0]   addr_s1;
	logic [slbm_pkg::DATA_W-1:0]   data_s1;

	logic                          vld_s2;
	logic                          hit_s2;
	logic [slbm_pkg::MAP_W-1:0]    maddr_s2;
	logic [1:0]                    mirror_s2;

	logic [slbm_pkg::COUNT_W-1:0]  prg_cnt_q, chr_cnt_q;

	logic                          adv;
	logic                          step;
	slbm_pkg::bank_state_t         st_nxt;
	logic                          hit;
	logic [slbm_pkg::MAP_W-1:0]    maddr;

	// The result stage moves when it is empty or being taken.
	assign adv      = !vld_s2 || m_tready;
	assign step     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_cnt_q <= slbm_pkg::PRG_COUNT_RST;
			chr_cnt_q <= slbm_pkg::CHR_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == slbm_pkg::REG_PRG_BANK_COUNT) begin
				prg_cnt_q <= cfg_data;
			end
			if (cfg_index == slbm_pkg::REG_CHR_BANK_COUNT) begin
				chr_cnt_q <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= slbm_pkg::cmd_t'(s_tuser);
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	slbm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.cmd     (cmd_s1),
		.address (addr_s1),
		.data    (data_s1),
		.st_nxt  (st_nxt)
	);

	slbm_xlate u_xlate (
		.cmd            (cmd_s1),
		.address        (addr_s1),
		.st             (st_nxt),
		.prg_bank_count (prg_cnt_q),
		.chr_bank_count (chr_cnt_q),
		.hit            (hit),
		.mapped_address (maddr)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_s2    <= hit;
			maddr_s2  <= maddr;
			mirror_s2 <= st_nxt.mirror;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = hit_s2;
	assign m_tdata  = {mirror_s2, maddr_s2};

endmodule

/* rtl/slbm_checker.sv */
// Port-level checks for the bank mapper core.
module slbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	// A pending result is held until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A miss never carries a mapped address.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[21:0] == 22'd0)
		else $error("miss with nonzero mapped address");

	// The input side only stalls behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	// A fresh result follows an accepted input transaction.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching input transaction");

endmodule

bind serial_loaded_bank_mapper_core slbm_checker u_slbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
